// File: sv/wfg_pkg.sv
`timescale 1ns / 1ps
package wfg_pkg;
   localparam int unsigned CMD_W = 3;
   localparam logic [2:0] CMD_ADD    = 3'd0;
   localparam logic [2:0] CMD_ADD_NT = 3'd1;
   localparam logic [2:0] CMD_DETECT = 3'd2;
   localparam logic [2:0] CMD_REMOVE = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;

   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_IGNORE = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      logic [2:0]  command;
      logic [1:0]  server;
      logic [2:0]  fiber;
      logic [31:0] stamp;
      logic [15:0] op_id;
      logic [1:0]  sender_server;
      logic [31:0] element_tag;
      logic [1:0]  target_server;
      logic [2:0]  target_fiber;
      logic [31:0] target_stamp;
      logic [15:0] target_op_id;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        deadlock;
      logic [1:0]  victim_server;
      logic [2:0]  victim_fiber;
      logic [31:0] victim_stamp;
      logic [15:0] victim_op_id;
      logic [31:0] victim_element_tag;
      logic [1:0]  victim_sender_server;
   } rsp_type;

   // One stored edge: server, fiber, stamp, op id.
   typedef struct packed {
      logic [1:0]  srv;
      logic [2:0]  fib;
      logic [31:0] stamp;
      logic [15:0] op;
   } edge_type;
   localparam int unsigned EDGE_W = $bits(edge_type);
endpackage

// File: sv/wait_for_graph_deadlock_detector_core.sv
`timescale 1ns / 1ps
// Wait-for graph deadlock detector. Each (server, fiber) transaction slot is a node
// holding a timestamp, operation id, abort mark, element tag, sender and a list of
// awaited targets kept in a RAM. Requests enter a two-entry transaction queue
// (push/full), a sequencer executes them one at a time, and results leave through
// a second two-entry queue (empty/pop). An add with a target writes its edge to the
// target-list RAM in a separate state before the result. A remove scans the target
// list and moves each following entry up by one place; a detection walk dequeues
// nodes and examines their edges one by one, both through the single read port of
// the target-list RAM.
module wait_for_graph_deadlock_detector_core #(
   parameter int unsigned SERVERS     = 4,
   parameter int unsigned FIBERS      = 8,
   parameter int unsigned MAX_TARGETS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  wfg_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output wfg_pkg::rsp_type rsp_data
);
   import wfg_pkg::*;

   logic    q_empty, q_take, r_valid, r_full;
   req_type q_data;
   rsp_type r_data;

   wfg_fifo #(.WIDTH($bits(req_type))) u_req_q (
      .clock(clock), .reset(reset), .push(push), .din(req_data), .full(full),
      .pop(q_take), .dout(q_data), .empty(q_empty)
   );

   wfg_engine #(.SERVERS(SERVERS), .FIBERS(FIBERS), .MAX_TARGETS(MAX_TARGETS)) u_eng (
      .clock(clock), .reset(reset), .cmd_valid(!q_empty), .cmd(q_data),
      .cmd_take(q_take), .rsp_valid(r_valid), .rsp(r_data), .rsp_full(r_full)
   );

   wfg_fifo #(.WIDTH($bits(rsp_type))) u_rsp_q (
      .clock(clock), .reset(reset), .push(r_valid), .din(r_data), .full(r_full),
      .pop(pop), .dout(rsp_data), .empty(empty)
   );
endmodule

// File: sv/wfg_ram.sv
`timescale 1ns / 1ps
module wfg_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: sv/wfg_fifo.sv
`timescale 1ns / 1ps
module wfg_fifo #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   // Two-entry queue.
   logic [WIDTH-1:0] data_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       do_push, do_pop;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = data_ff[rd_ff];

   always_comb begin
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      rd_in    = rd_ff ^ do_pop;
      wr_in    = wr_ff ^ do_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
      if (do_push) data_ff[wr_ff] <= din;
   end
endmodule

// File: sv/wfg_engine.sv
`timescale 1ns / 1ps
module wfg_engine #(
   parameter int unsigned SERVERS     = 4,
   parameter int unsigned FIBERS      = 8,
   parameter int unsigned MAX_TARGETS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  wfg_pkg::req_type cmd,
   output logic             cmd_take,
   output logic             rsp_valid,
   output wfg_pkg::rsp_type rsp,
   input  logic             rsp_full
);
   import wfg_pkg::*;

   localparam int unsigned NODES = SERVERS * FIBERS;
   localparam int unsigned NW    = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int unsigned TW    = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
   localparam int unsigned LW    = $clog2(MAX_TARGETS + 1);
   localparam int unsigned QW    = $clog2(NODES + 1);
   localparam int unsigned AW    = NW + TW;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_WPOP   = 9'b000000010,
      S_WNODE  = 9'b000000100,
      S_WREAD  = 9'b000001000,
      S_WEDGE  = 9'b000010000,
      S_RREAD  = 9'b000100000,
      S_RCHK   = 9'b001000000,
      S_SHIFT  = 9'b010000000,
      S_RESP   = 9'b100000000
   } state_type;

   state_type state_ff;

   logic [31:0]    nstamp_ff [NODES];
   logic [15:0]    nop_ff    [NODES];
   logic [31:0]    ntag_ff   [NODES];
   logic [1:0]     nsnd_ff   [NODES];
   logic [LW-1:0]  nlen_ff   [NODES];
   logic [NODES-1:0] nabort_ff;

   logic [NODES-1:0] visited_ff, enq_ff;
   logic [NW-1:0]    queue_ff [NODES];
   logic [QW-1:0]    qrd_ff, qwr_ff;

   logic          grp_open_ff, grp_rej_ff;
   logic [NW-1:0] grp_node_ff;

   req_type       c_ff;
   logic [NW-1:0] node_ff;
   logic [NW-1:0] cur_ff;
   logic [LW-1:0] idx_ff;
   rsp_type       r_ff;

   logic            ram_we;
   logic [AW-1:0]   ram_wa, ram_ra;
   logic [EDGE_W-1:0] ram_wd, ram_rd;
   edge_type        e_rd;
   assign e_rd = edge_type'(ram_rd);

   wfg_ram #(.WIDTH(EDGE_W), .DEPTH(NODES * (2 ** TW))) u_lists (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   logic          valid_a;
   logic [NW-1:0] n_a;
   always_comb begin
      valid_a = ({30'd0, cmd.server} < SERVERS) && ({29'd0, cmd.fiber} < FIBERS);
      n_a = valid_a ? NW'({30'd0, cmd.server} * FIBERS + {29'd0, cmd.fiber}) : '0;
   end

   edge_type key;
   assign key = '{srv: c_ff.target_server, fib: c_ff.target_fiber,
                  stamp: c_ff.target_stamp, op: c_ff.target_op_id};

   logic          e_ok;
   logic [NW-1:0] e_w;
   always_comb begin
      e_ok = ({30'd0, e_rd.srv} < SERVERS) && ({29'd0, e_rd.fib} < FIBERS);
      e_w  = e_ok ? NW'({30'd0, e_rd.srv} * FIBERS + {29'd0, e_rd.fib}) : '0;
      e_ok = e_ok && (nstamp_ff[e_w] == e_rd.stamp);
   end

   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_valid = (state_ff == S_RESP) && !rsp_full;
   assign rsp       = r_ff;

   always_comb begin
      ram_we = 1'b0;
      ram_wa = {node_ff, idx_ff[TW-1:0]};
      ram_wd = EDGE_W'(key);
      ram_ra = {cur_ff, idx_ff[TW-1:0]};
      case (state_ff)
         S_WPOP:  ram_we = 1'b1;
         S_RREAD: ram_ra = {node_ff, idx_ff[TW-1:0]};
         S_RCHK:  ram_ra = {node_ff, TW'(idx_ff + LW'(1))};
         S_SHIFT: begin
            ram_ra = {node_ff, TW'(idx_ff + LW'(2))};
            ram_we = 1'b1;
            ram_wd = ram_rd;
         end
         default: ;
      endcase
   end

   // Control and node store.  Add groups, decisions and list edits are
   // done from the captured request; walks and removals step through RAM.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         grp_open_ff <= 1'b0;
         grp_rej_ff  <= 1'b0;
         grp_node_ff <= '0;
         nabort_ff   <= '0;
         for (int i = 0; i < NODES; i++) begin
            nstamp_ff[i] <= '0;
            nop_ff[i]    <= '0;
            ntag_ff[i]   <= '0;
            nsnd_ff[i]   <= '0;
            nlen_ff[i]   <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: if (cmd_valid) begin
               automatic logic acc;
               automatic logic [NW-1:0] tn;
               automatic logic gopen;
               automatic logic grej;
               c_ff    <= cmd;
               node_ff <= n_a;
               r_ff    <= '0;
               state_ff <= S_RESP;
               gopen = grp_open_ff && (cmd.command == CMD_ADD);
               grej  = grp_rej_ff;
               tn    = grp_node_ff;
               acc   = 1'b0;
               if (cmd.command == CMD_ADD_NT || (cmd.command == CMD_ADD && !gopen)) begin
                  if (valid_a) begin
                     if (nstamp_ff[n_a] > cmd.stamp) acc = 1'b0;
                     else if (nstamp_ff[n_a] == cmd.stamp) begin
                        if (nabort_ff[n_a] || nop_ff[n_a] > cmd.op_id) acc = 1'b0;
                        else begin
                           acc = 1'b1;
                           if (nop_ff[n_a] < cmd.op_id) begin
                              nlen_ff[n_a] <= '0;
                              nop_ff[n_a]  <= cmd.op_id;
                           end
                           ntag_ff[n_a] <= cmd.element_tag;
                           nsnd_ff[n_a] <= cmd.sender_server;
                        end
                     end else begin
                        acc = 1'b1;
                        nstamp_ff[n_a] <= cmd.stamp;
                        nop_ff[n_a]    <= cmd.op_id;
                        ntag_ff[n_a]   <= cmd.element_tag;
                        nsnd_ff[n_a]   <= cmd.sender_server;
                        nlen_ff[n_a]   <= '0;
                        nabort_ff[n_a] <= 1'b0;
                     end
                  end
               end
               case (cmd.command)
                  CMD_ADD: begin
                     if (!gopen) begin
                        grej = !acc;
                        tn   = n_a;
                     end
                     grp_node_ff <= tn;
                     grp_rej_ff  <= grej;
                     grp_open_ff <= !cmd.last;
                     node_ff     <= tn;
                     if (grej) r_ff.status <= ST_IGNORE;
                     else begin
                        // A fresh decision may have emptied the list.
                        automatic logic [LW-1:0] len;
                        len = (!gopen && acc &&
                               (nstamp_ff[n_a] != cmd.stamp || nop_ff[n_a] < cmd.op_id))
                              ? '0 : nlen_ff[tn];
                        if ({{(32-LW){1'b0}}, len} >= MAX_TARGETS) r_ff.status <= ST_FULL;
                        else begin
                           idx_ff <= len;
                           nlen_ff[tn] <= len + LW'(1);
                           state_ff <= S_WPOP; // the edge is written in S_WPOP
                        end
                     end
                  end
                  CMD_ADD_NT: begin
                     grp_open_ff <= 1'b0;
                     r_ff.status <= acc ? ST_DONE : ST_IGNORE;
                  end
                  CMD_DETECT: begin
                     grp_open_ff <= 1'b0;
                     if (!valid_a || nstamp_ff[n_a] != cmd.stamp)
                        r_ff.status <= ST_IGNORE;
                     else begin
                        visited_ff  <= '0;
                        enq_ff      <= '0;
                        queue_ff[0] <= n_a;
                        qrd_ff      <= '0;
                        qwr_ff      <= QW'(1);
                        state_ff    <= S_WNODE;
                     end
                  end
                  CMD_REMOVE: begin
                     grp_open_ff <= 1'b0;
                     r_ff.status <= ST_IGNORE;
                     if (valid_a) begin
                        idx_ff   <= '0;
                        state_ff <= S_RREAD;
                     end
                  end
                  CMD_CLEAR: begin
                     grp_open_ff <= 1'b0;
                     if (valid_a) begin
                        nlen_ff[n_a]   <= '0;
                        nabort_ff[n_a] <= 1'b1;
                     end else r_ff.status <= ST_IGNORE;
                  end
                  default: begin
                     grp_open_ff <= 1'b0;
                     r_ff.status <= ST_IGNORE;
                  end
               endcase
            end
            S_WPOP: state_ff <= S_RESP; // the edge is written in this cycle
            S_WNODE: begin
               if (qrd_ff >= qwr_ff) state_ff <= S_RESP;
               else begin
                  automatic logic [NW-1:0] n;
                  n = queue_ff[qrd_ff[NW-1:0]];
                  qrd_ff <= qrd_ff + QW'(1);
                  if (!visited_ff[n]) begin
                     visited_ff[n] <= 1'b1;
                     cur_ff <= n;
                     idx_ff <= '0;
                     state_ff <= (nlen_ff[n] == '0) ? S_WNODE : S_WREAD;
                  end
               end
            end
            S_WREAD: state_ff <= S_WEDGE;
            S_WEDGE: begin
               if (e_ok && e_w == node_ff) begin
                  r_ff.deadlock             <= 1'b1;
                  r_ff.victim_server        <= c_ff.server;
                  r_ff.victim_fiber         <= c_ff.fiber;
                  r_ff.victim_stamp         <= nstamp_ff[node_ff];
                  r_ff.victim_op_id         <= nop_ff[node_ff];
                  r_ff.victim_element_tag   <= ntag_ff[node_ff];
                  r_ff.victim_sender_server <= nsnd_ff[node_ff];
                  state_ff <= S_RESP;
               end else begin
                  if (e_ok && !enq_ff[e_w] && {{(32-QW){1'b0}}, qwr_ff} < NODES) begin
                     enq_ff[e_w] <= 1'b1;
                     queue_ff[qwr_ff[NW-1:0]] <= e_w;
                     qwr_ff <= qwr_ff + QW'(1);
                  end
                  idx_ff <= idx_ff + LW'(1);
                  state_ff <= (idx_ff + LW'(1) >= nlen_ff[cur_ff]) ? S_WNODE : S_WREAD;
               end
            end
            S_RREAD: begin
               if (idx_ff >= nlen_ff[node_ff]) state_ff <= S_RESP;
               else state_ff <= S_RCHK;
            end
            S_RCHK: begin
               if (ram_rd == EDGE_W'(key)) begin
                  r_ff.status <= ST_DONE;
                  nlen_ff[node_ff] <= nlen_ff[node_ff] - LW'(1);
                  // The entry after the match is read in this cycle for the shift.
                  state_ff <= (idx_ff + LW'(1) >= nlen_ff[node_ff]) ? S_RESP : S_SHIFT;
               end else begin
                  idx_ff <= idx_ff + LW'(1);
                  state_ff <= S_RREAD;
               end
            end
            S_SHIFT: begin
               // Each cycle moves one following entry up by one place.
               idx_ff <= idx_ff + LW'(1);
               if (idx_ff + LW'(1) >= nlen_ff[node_ff]) state_ff <= S_RESP;
            end
            S_RESP: if (!rsp_full) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the wait-for graph deadlock detector. A predictor
// mirrors the node table, the target lists and the add-group state, works out
// the one result each transaction causes, and queues it. A monitor compares
// every popped result field by field with the oldest queued expectation.
module testbench;
   import wfg_pkg::*;

   localparam int SERVERS = 4;
   localparam int FIBERS = 8;
   localparam int MAX_TARGETS = 32;
   localparam int NODES = SERVERS * FIBERS;
   localparam int CYCLE_LIMIT = 20000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full;
   logic empty;
   req_type req_data = '0;
   rsp_type rsp_data;

   wait_for_graph_deadlock_detector_core uut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor copy of the graph.
   logic [31:0] graph_stamp[NODES];
   logic [15:0] graph_op[NODES];
   logic graph_aborted[NODES];
   logic [31:0] graph_tag[NODES];
   logic [1:0] graph_sender[NODES];
   int graph_len[NODES];
   edge_type graph_edges[NODES][MAX_TARGETS];
   logic group_open = 1'b0;
   logic group_reject = 1'b0;
   int group_node = 0;

   rsp_type expected_results[$];
   int error_count = 0;
   longint cycle_count = 0;
   int stall_mode = 0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Add decision for the first item of a group and for add without targets.
   function automatic logic admit_request(input int n, input req_type r);
      if (graph_stamp[n] > r.stamp) return 1'b0;
      if (graph_stamp[n] == r.stamp) begin
         if (graph_aborted[n] || graph_op[n] > r.op_id) return 1'b0;
         if (graph_op[n] < r.op_id) begin
            graph_len[n] = 0;
            graph_op[n] = r.op_id;
         end
         graph_tag[n] = r.element_tag;
         graph_sender[n] = r.sender_server;
         return 1'b1;
      end
      graph_stamp[n] = r.stamp;
      graph_op[n] = r.op_id;
      graph_tag[n] = r.element_tag;
      graph_sender[n] = r.sender_server;
      graph_len[n] = 0;
      graph_aborted[n] = 1'b0;
      return 1'b1;
   endfunction

   // Breadth-first search for a path that leads back to the start node.
   function automatic logic finds_cycle(input int start);
      logic seen[NODES];
      logic queued[NODES];
      int order[$];
      int n;
      int w;
      foreach (seen[i]) begin
         seen[i] = 1'b0;
         queued[i] = 1'b0;
      end
      order.push_back(start);
      while (order.size() > 0) begin
         n = order.pop_front();
         if (seen[n]) continue;
         seen[n] = 1'b1;
         for (int i = 0; i < graph_len[n]; i++) begin
            w = graph_edges[n][i].srv * FIBERS + graph_edges[n][i].fib;
            if (graph_stamp[w] != graph_edges[n][i].stamp) continue;
            if (w == start) return 1'b1;
            if (!queued[w]) begin
               queued[w] = 1'b1;
               order.push_back(w);
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_type predict_result(input req_type r);
      rsp_type res;
      int n;
      edge_type key;
      res = '0;
      n = r.server * FIBERS + r.fiber;
      key = '{srv: r.target_server, fib: r.target_fiber, stamp: r.target_stamp,
              op: r.target_op_id};
      if (r.command != CMD_ADD) group_open = 1'b0;
      case (r.command)
         CMD_ADD: begin
            if (!group_open) begin
               group_open = 1'b1;
               group_node = n;
               group_reject = !admit_request(n, r);
            end
            if (group_reject) res.status = ST_IGNORE;
            else if (graph_len[group_node] >= MAX_TARGETS) res.status = ST_FULL;
            else begin
               graph_edges[group_node][graph_len[group_node]] = key;
               graph_len[group_node]++;
            end
            if (r.last) group_open = 1'b0;
         end
         CMD_ADD_NT: res.status = admit_request(n, r) ? ST_DONE : ST_IGNORE;
         CMD_DETECT: begin
            if (graph_stamp[n] != r.stamp) res.status = ST_IGNORE;
            else if (finds_cycle(n)) begin
               res.deadlock = 1'b1;
               res.victim_server = r.server;
               res.victim_fiber = r.fiber;
               res.victim_stamp = graph_stamp[n];
               res.victim_op_id = graph_op[n];
               res.victim_element_tag = graph_tag[n];
               res.victim_sender_server = graph_sender[n];
            end
         end
         CMD_REMOVE: begin
            res.status = ST_IGNORE;
            for (int i = 0; i < graph_len[n]; i++) begin
               if (graph_edges[n][i] == key) begin
                  for (int k = i; k < graph_len[n] - 1; k++)
                     graph_edges[n][k] = graph_edges[n][k + 1];
                  graph_len[n]--;
                  res.status = ST_DONE;
                  break;
               end
            end
         end
         CMD_CLEAR: begin
            graph_len[n] = 0;
            graph_aborted[n] = 1'b1;
         end
         default: res.status = ST_IGNORE;
      endcase
      return res;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // Sends one transaction; the expectation is formed when it is accepted.
   task automatic send_request(input req_type r);
      int gap;
      gap = (stall_mode == 1) ? 0 : pick_gap();
      if (push) begin
         // Keep push high through a zero gap; otherwise drop it for the gap.
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      expected_results.push_back(predict_result(r));
   endtask

   task automatic go_idle();
      push <= 1'b0;
      @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
   endtask

   // Result side: random pop stalls, and each popped result is checked.
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && pop && !empty) begin
         if (expected_results.size() == 0) begin
            report("unexpected result", 64'(rsp_data), 64'd0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.status !== want.status)
               report("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.deadlock !== want.deadlock)
               report("deadlock", 64'(rsp_data.deadlock), 64'(want.deadlock));
            if (rsp_data.victim_server !== want.victim_server)
               report("victim_server", 64'(rsp_data.victim_server),
                      64'(want.victim_server));
            if (rsp_data.victim_fiber !== want.victim_fiber)
               report("victim_fiber", 64'(rsp_data.victim_fiber), 64'(want.victim_fiber));
            if (rsp_data.victim_stamp !== want.victim_stamp)
               report("victim_stamp", 64'(rsp_data.victim_stamp), 64'(want.victim_stamp));
            if (rsp_data.victim_op_id !== want.victim_op_id)
               report("victim_op_id", 64'(rsp_data.victim_op_id), 64'(want.victim_op_id));
            if (rsp_data.victim_element_tag !== want.victim_element_tag)
               report("victim_element_tag", 64'(rsp_data.victim_element_tag),
                      64'(want.victim_element_tag));
            if (rsp_data.victim_sender_server !== want.victim_sender_server)
               report("victim_sender_server", 64'(rsp_data.victim_sender_server),
                      64'(want.victim_sender_server));
         end
      end
      if (stall_mode == 1) pop <= 1'b1;
      else if ($urandom_range(0, 29) == 0) pop <= 1'b0;
      else if ($urandom_range(0, 2) != 0) pop <= 1'b1;
      else pop <= ($urandom_range(0, 9) == 0) ? 1'b0 : pop;
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic req_type make_request(input logic [2:0] cmd, input int srv, input int fib,
                                            input logic [31:0] st, input logic [15:0] op);
      req_type r;
      r = '0;
      r.command = cmd;
      r.server = 2'(srv);
      r.fiber = 3'(fib);
      r.stamp = st;
      r.op_id = op;
      r.sender_server = 2'($urandom());
      r.element_tag = $urandom();
      r.last = 1'b1;
      return r;
   endfunction

   function automatic req_type with_target(input req_type r, input int tsrv, input int tfib,
                                           input logic [31:0] tst, input logic [15:0] top,
                                           input logic last);
      r.target_server = 2'(tsrv);
      r.target_fiber = 3'(tfib);
      r.target_stamp = tst;
      r.target_op_id = top;
      r.last = last;
      return r;
   endfunction

   // Extremes, every command, stale and replacing adds, a two-node cycle,
   // remove hit and miss, clear and aborted rejection, and unknown commands.
   task automatic test_directed();
      send_request(with_target(make_request(CMD_ADD, 0, 0, 32'd10, 16'd5), 3, 7, 32'd20,
                               16'hFFFF, 1'b0));
      send_request(with_target(make_request(CMD_ADD, 2, 2, 0, 0), 1, 1, 32'd20, 0, 1'b1));
      send_request(with_target(make_request(CMD_ADD, 3, 7, 32'd20, 16'd1), 0, 0, 32'd10, 0,
                               1'b1));
      send_request(make_request(CMD_DETECT, 0, 0, 32'd10, 0));
      send_request(make_request(CMD_DETECT, 3, 7, 32'd20, 0));
      send_request(make_request(CMD_DETECT, 3, 7, 32'd21, 0));
      send_request(make_request(CMD_ADD_NT, 0, 0, 32'd9, 16'd9));
      send_request(make_request(CMD_ADD_NT, 0, 0, 32'd10, 16'd4));
      send_request(make_request(CMD_ADD_NT, 0, 0, 32'd10, 16'd5));
      send_request(with_target(make_request(CMD_REMOVE, 0, 0, 0, 0), 3, 7, 32'd20, 16'd1,
                               1'b1));
      send_request(with_target(make_request(CMD_REMOVE, 0, 0, 0, 0), 3, 7, 32'd20, 16'hFFFF,
                               1'b1));
      send_request(make_request(CMD_ADD_NT, 3, 7, 32'd20, 16'd2));
      send_request(make_request(CMD_CLEAR, 3, 7, 0, 0));
      send_request(make_request(CMD_ADD_NT, 3, 7, 32'd20, 16'd2));
      send_request(make_request(CMD_ADD_NT, 3, 7, 32'hFFFF_FFFF, 16'hFFFF));
      send_request(make_request(3'd5, 1, 1, 0, 0));
      send_request(make_request(3'd7, 1, 1, 0, 0));
      send_request(make_request(CMD_DETECT, 2, 5, 0, 0));
      go_idle();
   endtask

   // Fill one list past its capacity so targets are dropped.
   task automatic test_full_list();
      for (int i = 0; i < MAX_TARGETS + 3; i++)
         send_request(with_target(make_request(CMD_ADD, 1, 3, 32'd50, 16'd1), $urandom(),
                                  $urandom(), $urandom(), 16'($urandom()),
                                  i == MAX_TARGETS + 2));
      send_request(make_request(CMD_DETECT, 1, 3, 32'd50, 0));
      // An interrupted group, then a cleared node.
      send_request(with_target(make_request(CMD_ADD, 1, 4, 32'd60, 0), 1, 3, 32'd50, 0, 1'b0));
      send_request(make_request(CMD_CLEAR, 1, 3, 0, 0));
      go_idle();
   endtask

   // Random traffic: mostly well-formed groups over a few stamps so that
   // edges match stored stamps and cycles form, plus noise.
   task automatic test_random(input int count);
      int sent;
      int len;
      int n;
      logic [31:0] st;
      req_type r;
      sent = 0;
      while (sent < count) begin
         n = $urandom_range(0, 99);
         st = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 3);
         r = make_request(CMD_ADD, $urandom(), $urandom(), st, 16'($urandom_range(0, 2)));
         if ($urandom_range(0, 19) == 0) r.op_id = 16'($urandom());
         if (n < 45) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 36) : $urandom_range(1, 3);
            for (int i = 0; i < len; i++) begin
               send_request(with_target(r, $urandom(), $urandom(),
                            ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 3),
                            16'($urandom_range(0, 2)), i == len - 1));
               sent++;
            end
         end else begin
            if (n < 55) r.command = CMD_ADD_NT;
            else if (n < 78) r.command = CMD_DETECT;
            else if (n < 90) r.command = CMD_REMOVE;
            else if (n < 96) r.command = CMD_CLEAR;
            else r.command = 3'($urandom_range(0, 7));
            r = with_target(r, $urandom(), $urandom(), $urandom_range(0, 3),
                            16'($urandom_range(0, 2)), 1'($urandom()));
            if ($urandom_range(0, 30) == 0)
               r = $bits(req_type)'({$urandom(), $urandom(), $urandom(),
                                     $urandom(), $urandom()});
            send_request(r);
            sent++;
         end
         if (sent > count / 2 && stall_mode == 0 && $urandom_range(0, 3) == 0) begin
            // A stretch with no idling on either side.
            stall_mode = 1;
         end else if (stall_mode == 1 && $urandom_range(0, 9) == 0) begin
            stall_mode = 0;
         end
      end
      stall_mode = 0;
      go_idle();
   endtask

   initial begin
      for (int i = 0; i < NODES; i++) begin
         graph_stamp[i] = '0;
         graph_op[i] = '0;
         graph_aborted[i] = 1'b0;
         graph_tag[i] = '0;
         graph_sender[i] = '0;
         graph_len[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_list();
      test_random(600);
      // The sender holds off here until all results are back (go_idle above).
      test_random(600);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
